### src/cudm_pkg.sv
// cudm_pkg: shared constants, codes and types of the CPU usage delta monitor.
// Depends on nothing; used by the interfaces, the divider and the top level.
package cudm_pkg;

  // Sizing
  localparam int MAX_CORES  = 8;
  localparam int MAX_ROWS   = 64;
  localparam int TIME_W     = 64;
  localparam int PID_W      = 31;
  localparam int CORE_IDX_W = 3;
  localparam int COUNT_W    = 8;
  localparam int POS_W      = 6;
  localparam int PCT_W      = 7;
  localparam int CORES_W    = $clog2(MAX_CORES + 1);
  localparam int IDLE_AW    = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
  localparam int ROWS_W     = $clog2(MAX_ROWS + 1);
  localparam int ROW_AW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ROW_DEPTH  = 2 * (2 ** ROW_AW);
  localparam int PCT_FULL   = 100;
  localparam int SUM_W      = $clog2(PCT_FULL * MAX_CORES + 1);
  localparam int MUL_W      = $clog2(PCT_FULL + 1);
  localparam int DVD_W      = TIME_W + MUL_W;
  localparam int DCNT_W     = $clog2(DVD_W + 1);

  // Item codes
  localparam logic [1:0] FUNC_BEGIN = 2'd0;
  localparam logic [1:0] FUNC_CORE  = 2'd1;
  localparam logic [1:0] FUNC_ROW   = 2'd2;
  localparam logic [1:0] FUNC_END   = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_CORE  = 2'd0;
  localparam logic [1:0] KIND_PROC  = 2'd1;
  localparam logic [1:0] KIND_TOTAL = 2'd2;

  // One stored process row
  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [TIME_W-1:0] cpu_time;
  } row_ent_t;

  // Divider request and status
  typedef struct packed {
    logic start;
    logic short_op;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage

### src/cudm_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on cudm_pkg for field widths.
interface cudm_in_if;
  import cudm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [1:0]            func;
  logic [TIME_W-1:0]     time_ns;
  logic [COUNT_W-1:0]    core_count;
  logic [CORE_IDX_W-1:0] core_index;
  logic [TIME_W-1:0]     counter_ns;
  logic [PID_W-1:0]      pid;

  modport source (output valid, func, time_ns, core_count, core_index, counter_ns, pid,
                  input ready);
  modport sink   (input valid, func, time_ns, core_count, core_index, counter_ns, pid,
                  output ready);
endinterface

interface cudm_out_if;
  import cudm_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [POS_W-1:0] position;
  logic [PID_W-1:0] pid_echo;
  logic [PCT_W-1:0] percent;
  logic             matched;

  modport source (output valid, kind, position, pid_echo, percent, matched, input ready);
  modport sink   (input valid, kind, position, pid_echo, percent, matched, output ready);
endinterface

### src/cudm_ram.sv
// cudm_ram: generic single-clock RAM, one write port, one registered read port.
// No dependencies.
module cudm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/cudm_div.sv
// cudm_div: restoring divider, one quotient bit per cycle.
// Depends on cudm_pkg. A short operation divides only the top SUM_W bits.
module cudm_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cudm_pkg::div_req_t        req_i,
  input  logic [cudm_pkg::DVD_W-1:0]  dividend_i,
  input  logic [cudm_pkg::TIME_W-1:0] divisor_i,
  output cudm_pkg::div_rsp_t        rsp_o,
  output logic [cudm_pkg::DVD_W-1:0]  quotient_o
);
  import cudm_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [TIME_W-1:0] rem_q, rem_d;
  logic [TIME_W-1:0] dvs_q, dvs_d;
  logic [DVD_W-1:0]  dvd_q, dvd_d;
  logic [DVD_W-1:0]  quo_q, quo_d;
  logic [TIME_W:0]   trial;
  logic [TIME_W:0]   diff;
  logic              take;

  // One shift-compare-subtract step
  always_comb begin
    trial = {rem_q, dvd_q[DVD_W-1]};
    diff  = trial - {1'b0, dvs_q};
    take  = (trial >= {1'b0, dvs_q});
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.short_op ? DCNT_W'(SUM_W) : DCNT_W'(DVD_W);
      rem_d  = '0;
      dvs_d  = divisor_i;
      dvd_d  = dividend_i;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = take ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
      quo_d = {quo_q[DVD_W-2:0], take};
      cnt_d = cnt_q - DCNT_W'(1);
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign quotient_o = quo_q;

`ifndef NO_ASSERTIONS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running operation");
  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider still busy at done");
`endif

endmodule

### src/cpu_usage_delta_monitor.sv
// Work per item: begin gives no result; a row first runs the pid search at one RAM read
// a cycle. Then, at nonzero interval, core runs a 71-step serial divide, total a 10-step
// one, a matched row a 71-step one and, unless it saturates, a 10-step one.
// One item is worked on at a time; the next item is taken while a result waits in the
// output register. Reset: asynchronous, active low; control state, valid bits and
// counters clear. Top level: state machine around the row RAM, idle RAM and cudm_div.
module cpu_usage_delta_monitor (
  input logic      clk_i,
  input logic      rst_ni,
  cudm_in_if.sink  in_i,
  cudm_out_if.source out_o
);
  import cudm_pkg::*;

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE    = 4'd0;
  localparam logic [ST_W-1:0] S_CORE_RD = 4'd1;
  localparam logic [ST_W-1:0] S_SRCH    = 4'd2;
  localparam logic [ST_W-1:0] S_ROW_WR  = 4'd3;
  localparam logic [ST_W-1:0] S_MUL     = 4'd4;
  localparam logic [ST_W-1:0] S_DSTART  = 4'd5;
  localparam logic [ST_W-1:0] S_DWAIT   = 4'd6;
  localparam logic [ST_W-1:0] S_EMIT    = 4'd7;

  localparam int RAW = $clog2(ROW_DEPTH);

  // Control and state registers
  logic [ST_W-1:0]       state_q, state_d;
  logic                  have_prev_q, have_prev_d;
  logic [TIME_W-1:0]     last_time_q, last_time_d;
  logic [TIME_W-1:0]     interval_q, interval_d;
  logic [CORES_W-1:0]    cores_q, cores_d;
  logic [SUM_W-1:0]      busy_sum_q, busy_sum_d;
  logic [MAX_CORES-1:0]  idle_vld_q, idle_vld_d;
  logic                  bank_q, bank_d;
  logic [ROWS_W-1:0]     prev_rows_q, prev_rows_d;
  logic [ROWS_W-1:0]     cur_rows_q, cur_rows_d;
  logic [ROWS_W-1:0]     j_q, j_d;
  logic                  cmp_q, cmp_d;
  logic                  small_q, small_d;
  logic                  out_vld_q, out_vld_d;

  // Item and datapath registers
  logic [1:0]            func_q, func_d;
  logic [CORE_IDX_W-1:0] idx_q, idx_d;
  logic [TIME_W-1:0]     counter_q, counter_d;
  logic [PID_W-1:0]      pid_q, pid_d;
  logic [ROWS_W-1:0]     pos_q, pos_d;
  logic                  found_q, found_d;
  logic [TIME_W-1:0]     prev_time_q, prev_time_d;
  logic [TIME_W-1:0]     delta_q, delta_d;
  logic [DVD_W-1:0]      dvd_q, dvd_d;
  logic [TIME_W-1:0]     dvs_q, dvs_d;
  logic [PCT_W-1:0]      pct_q, pct_d;
  logic [1:0]            o_kind_q, o_kind_d;
  logic [POS_W-1:0]      o_pos_q, o_pos_d;
  logic [PID_W-1:0]      o_pid_q, o_pid_d;
  logic [PCT_W-1:0]      o_pct_q, o_pct_d;
  logic                  o_match_q, o_match_d;

  // Memory and divider hookup
  logic                  row_we, row_re;
  logic [RAW-1:0]        row_waddr, row_raddr;
  row_ent_t              row_wdata, row_rdata;
  logic                  idle_we, idle_re;
  logic [IDLE_AW-1:0]    idle_addr;
  logic [TIME_W-1:0]     idle_rdata;
  div_req_t              div_req;
  div_rsp_t              div_rsp;
  logic [DVD_W-1:0]      quo;

  // Combinational helpers
  logic                  in_acc;
  logic [SUM_W-1:0]      sum_limit;
  logic [TIME_W-1:0]     prev_idle;
  logic [TIME_W-1:0]     diff;
  logic [SUM_W:0]        sum_add;
  logic                  hit;

  cudm_ram #(.WIDTH(PID_W + TIME_W), .DEPTH(ROW_DEPTH)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (row_wdata),
    .re_i    (row_re),
    .raddr_i (row_raddr),
    .rdata_o (row_rdata)
  );

  cudm_ram #(.WIDTH(TIME_W), .DEPTH(2 ** IDLE_AW)) u_idle_ram (
    .clk_i   (clk_i),
    .we_i    (idle_we),
    .waddr_i (idle_addr),
    .wdata_i (counter_q),
    .re_i    (idle_re),
    .raddr_i (idle_addr),
    .rdata_o (idle_rdata)
  );

  cudm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (dvd_q),
    .divisor_i  (dvs_q),
    .rsp_o      (div_rsp),
    .quotient_o (quo)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign sum_limit  = SUM_W'(cores_q) * SUM_W'(PCT_FULL);
  assign prev_idle  = idle_vld_q[idx_q[IDLE_AW-1:0]] ? idle_rdata : '0;
  assign hit        = cmp_q && (row_rdata.pid == pid_q);

  // Main sequencer
  always_comb begin
    state_d     = state_q;
    have_prev_d = have_prev_q;
    last_time_d = last_time_q;
    interval_d  = interval_q;
    cores_d     = cores_q;
    busy_sum_d  = busy_sum_q;
    idle_vld_d  = idle_vld_q;
    bank_d      = bank_q;
    prev_rows_d = prev_rows_q;
    cur_rows_d  = cur_rows_q;
    j_d         = j_q;
    cmp_d       = 1'b0;
    small_d     = small_q;
    func_d      = func_q;
    idx_d       = idx_q;
    counter_d   = counter_q;
    pid_d       = pid_q;
    pos_d       = pos_q;
    found_d     = found_q;
    prev_time_d = prev_time_q;
    delta_d     = delta_q;
    dvd_d       = dvd_q;
    dvs_d       = dvs_q;
    pct_d       = pct_q;
    row_we      = 1'b0;
    row_re      = 1'b0;
    row_waddr   = {bank_q, pos_q[ROW_AW-1:0]};
    row_raddr   = {~bank_q, j_q[ROW_AW-1:0]};
    row_wdata   = '{pid: pid_q, cpu_time: counter_q};
    idle_we     = 1'b0;
    idle_re     = 1'b0;
    idle_addr   = idx_q[IDLE_AW-1:0];
    div_req     = '{start: 1'b0, short_op: small_q};
    diff        = '0;
    sum_add     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          func_d    = in_i.func;
          idx_d     = in_i.core_index;
          counter_d = in_i.counter_ns;
          pid_d     = in_i.pid;
          pos_d     = cur_rows_q;
          found_d   = 1'b0;
          j_d       = '0;
          unique case (in_i.func)
            FUNC_BEGIN: begin
              interval_d  = have_prev_q ? (in_i.time_ns - last_time_q) : '0;
              last_time_d = in_i.time_ns;
              have_prev_d = 1'b1;
              if (in_i.core_count == '0 ||
                  in_i.core_count > COUNT_W'(MAX_CORES)) begin
                cores_d = CORES_W'(1);
              end else begin
                cores_d = CORES_W'(in_i.core_count);
              end
              busy_sum_d  = '0;
              prev_rows_d = cur_rows_q;
              bank_d      = ~bank_q;
              cur_rows_d  = '0;
            end
            FUNC_CORE: begin
              if (32'(in_i.core_index) < MAX_CORES) begin
                idle_re   = 1'b1;
                idle_addr = IDLE_AW'(in_i.core_index);
                state_d   = S_CORE_RD;
              end
            end
            FUNC_ROW: begin
              if (32'(cur_rows_q) < MAX_ROWS) begin
                state_d = S_SRCH;
              end
            end
            FUNC_END: begin
              if (interval_q == '0) begin
                pct_d   = '0;
                state_d = S_EMIT;
              end else begin
                dvd_d   = {busy_sum_q, {(DVD_W - SUM_W){1'b0}}};
                dvs_d   = TIME_W'(cores_q);
                small_d = 1'b1;
                state_d = S_DSTART;
              end
            end
            default: ;
          endcase
        end
      end

      // Idle counter read back: store the new value, compute the idle delta
      S_CORE_RD: begin
        idle_we    = 1'b1;
        idle_vld_d[idx_q[IDLE_AW-1:0]] = 1'b1;
        diff       = counter_q - prev_idle;
        if (CORES_W'(idx_q) >= cores_q) begin
          state_d = S_IDLE;
        end else if (interval_q == '0) begin
          pct_d   = '0;
          state_d = S_EMIT;
        end else begin
          delta_d = (diff > interval_q) ? interval_q : diff;
          state_d = S_MUL;
        end
      end

      // Pid search over the previous bank, one read issued a cycle
      S_SRCH: begin
        if (hit) begin
          found_d     = 1'b1;
          prev_time_d = row_rdata.cpu_time;
          state_d     = S_ROW_WR;
        end else if (j_q < prev_rows_q) begin
          row_re = 1'b1;
          cmp_d  = 1'b1;
          j_d    = j_q + ROWS_W'(1);
        end else begin
          state_d = S_ROW_WR;
        end
      end

      S_ROW_WR: begin
        row_we     = 1'b1;
        cur_rows_d = cur_rows_q + ROWS_W'(1);
        if (found_q && interval_q != '0) begin
          delta_d = counter_q - prev_time_q;
          state_d = S_MUL;
        end else begin
          pct_d   = '0;
          state_d = S_EMIT;
        end
      end

      // Scale delta by 100 ahead of the long divide
      S_MUL: begin
        dvd_d   = DVD_W'(delta_q) * DVD_W'(PCT_FULL);
        dvs_d   = interval_q;
        small_d = 1'b0;
        state_d = S_DSTART;
      end

      S_DSTART: begin
        div_req.start = 1'b1;
        state_d       = S_DWAIT;
      end

      S_DWAIT: begin
        if (div_rsp.done) begin
          if (small_q) begin
            pct_d   = quo[PCT_W-1:0];
            state_d = S_EMIT;
          end else if (func_q == FUNC_CORE) begin
            pct_d   = PCT_W'(PCT_FULL) - quo[PCT_W-1:0];
            sum_add = {1'b0, busy_sum_q} + (SUM_W + 1)'(pct_d);
            busy_sum_d = (sum_add > {1'b0, sum_limit}) ? sum_limit : sum_add[SUM_W-1:0];
            state_d = S_EMIT;
          end else if (quo >= DVD_W'(sum_limit)) begin
            pct_d   = PCT_W'(PCT_FULL);
            state_d = S_EMIT;
          end else begin
            dvd_d   = {quo[SUM_W-1:0], {(DVD_W - SUM_W){1'b0}}};
            dvs_d   = TIME_W'(cores_q);
            small_d = 1'b1;
            state_d = S_DSTART;
          end
        end
      end

      S_EMIT: begin
        if (!out_vld_q || out_o.ready) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Output register
  always_comb begin
    out_vld_d = out_vld_q && !out_o.ready;
    o_kind_d  = o_kind_q;
    o_pos_d   = o_pos_q;
    o_pid_d   = o_pid_q;
    o_pct_d   = o_pct_q;
    o_match_d = o_match_q;
    if (state_q == S_EMIT && (!out_vld_q || out_o.ready)) begin
      out_vld_d = 1'b1;
      o_pct_d   = pct_q;
      unique case (func_q)
        FUNC_CORE: begin
          o_kind_d  = KIND_CORE;
          o_pos_d   = POS_W'(idx_q);
          o_pid_d   = '0;
          o_match_d = 1'b0;
        end
        FUNC_ROW: begin
          o_kind_d  = KIND_PROC;
          o_pos_d   = POS_W'(pos_q);
          o_pid_d   = pid_q;
          o_match_d = found_q;
        end
        default: begin
          o_kind_d  = KIND_TOTAL;
          o_pos_d   = '0;
          o_pid_d   = '0;
          o_match_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      have_prev_q <= 1'b0;
      last_time_q <= '0;
      interval_q  <= '0;
      cores_q     <= CORES_W'(1);
      busy_sum_q  <= '0;
      idle_vld_q  <= '0;
      bank_q      <= 1'b0;
      prev_rows_q <= '0;
      cur_rows_q  <= '0;
      j_q         <= '0;
      cmp_q       <= 1'b0;
      small_q     <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      have_prev_q <= have_prev_d;
      last_time_q <= last_time_d;
      interval_q  <= interval_d;
      cores_q     <= cores_d;
      busy_sum_q  <= busy_sum_d;
      idle_vld_q  <= idle_vld_d;
      bank_q      <= bank_d;
      prev_rows_q <= prev_rows_d;
      cur_rows_q  <= cur_rows_d;
      j_q         <= j_d;
      cmp_q       <= cmp_d;
      small_q     <= small_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    idx_q       <= idx_d;
    counter_q   <= counter_d;
    pid_q       <= pid_d;
    pos_q       <= pos_d;
    found_q     <= found_d;
    prev_time_q <= prev_time_d;
    delta_q     <= delta_d;
    dvd_q       <= dvd_d;
    dvs_q       <= dvs_d;
    pct_q       <= pct_d;
    o_kind_q    <= o_kind_d;
    o_pos_q     <= o_pos_d;
    o_pid_q     <= o_pid_d;
    o_pct_q     <= o_pct_d;
    o_match_q   <= o_match_d;
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.kind     = o_kind_q;
  assign out_o.position = o_pos_q;
  assign out_o.pid_echo = o_pid_q;
  assign out_o.percent  = o_pct_q;
  assign out_o.matched  = o_match_q;

`ifndef NO_ASSERTIONS
  a_sum_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_sum_q <= sum_limit)
    else $error("busy sum above limit");
  a_rows_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cur_rows_q) <= MAX_ROWS && 32'(prev_rows_q) <= MAX_ROWS)
    else $error("row count above capacity");
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.percent <= PCT_W'(PCT_FULL))
    else $error("percent above full scale");
  a_search_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SRCH |-> j_q <= prev_rows_q)
    else $error("search ran past previous rows");
`endif

endmodule
